[sv/checkerboard_sublattice_address_gen_macros.svh]
// assertion macros used by the checker file
`ifndef CHECKERBOARD_SUBLATTICE_ADDRESS_GEN_MACROS_SVH
`define CHECKERBOARD_SUBLATTICE_ADDRESS_GEN_MACROS_SVH

// property checked outside reset
`define CSAG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property that also covers the reset cycles
`define CSAG_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[sv/csag_pkg.sv]
// shared types, constants and helpers of the checkerboard address generator
package csag_pkg;

   localparam int MAX_EXTENT  = 32;
   localparam int BLOCK_WORDS = 12;

   localparam int EXT_W      = 6;
   localparam int EXT_SUM_W  = EXT_W + 1;
   localparam int COORD_W    = 5;
   localparam int ADDR_W     = 23;
   localparam int LAST_W     = 4;
   localparam int HALF_W     = $clog2(MAX_EXTENT / 2 + 2);
   localparam int CSR_DATA_W = EXT_W;
   localparam int CSR_INDEX_W = 3;

   // product widths of the three multiply stages
   localparam int MUL1_W = 11;
   localparam int MUL2_W = 16;
   localparam int MUL3_W = 21;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [EXT_W-1:0] EXTENT_RESET = EXT_W'(8);
   localparam logic [EXT_W-1:0] EXTENT_MIN   = EXT_W'(1);
   localparam logic [EXT_W-1:0] EXTENT_MAX   = EXT_W'(MAX_EXTENT);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXTENT_X   = 3'd0,
      CSR_EXTENT_Y   = 3'd1,
      CSR_EXTENT_Z   = 3'd2,
      CSR_EXTENT_T   = 3'd3,
      CSR_SUB_PARITY = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [EXT_W-1:0] extent_x;
      logic [EXT_W-1:0] extent_y;
      logic [EXT_W-1:0] extent_z;
      logic [EXT_W-1:0] extent_t;
      logic             sublattice_parity;
   } cfg_type;

   typedef struct packed {
      logic               checkerboard;
      logic               boundary_pad;
      logic               shift_flag;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [COORD_W-1:0] coord_t;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_x_dir;
      logic [ADDR_W-1:0] addr_y_dir;
      logic [ADDR_W-1:0] addr_z_dir;
      logic [ADDR_W-1:0] addr_t_dir;
      logic [LAST_W-1:0] last_x_index;
      logic              coord_error;
   } rsp_type;

   // classified line request handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [COORD_W-1:0] coord_t;
      logic               disp;      // padding plus shift, always 0 or 1
      logic               x_pad_off; // padding plus shifted x start
      logic               x_off;     // unshifted x start
      logic [LAST_W-1:0]  last_x;
      logic               err;
   } work_type;

   // half extent along x, rounded up
   function automatic logic [HALF_W-1:0] half_extent(input logic [EXT_W-1:0] ext);
      logic [EXT_SUM_W-1:0] sum;
      sum = EXT_SUM_W'(ext) + EXT_SUM_W'(1);
      return HALF_W'(sum >> 1);
   endfunction

endpackage

[sv/csag_front.sv]
// front end: parity exchange, shift rule and line bounds of one request
module csag_front (
   input  csag_pkg::cfg_type  cfg,
   input  csag_pkg::req_type  req,
   output csag_pkg::work_type work
);
   import csag_pkg::*;

   logic              odd_x;
   logic              ceil_mode;
   logic              eff_cb;
   logic              start_odd;
   logic              ix;
   logic [HALF_W-1:0] half;
   logic [HALF_W-1:0] last_full;

   always_comb begin
      odd_x     = cfg.extent_x[0];
      half      = half_extent(cfg.extent_x);
      ceil_mode = odd_x & ~req.boundary_pad;
      eff_cb    = cfg.sublattice_parity ^ req.checkerboard;
      // a shift of plus or minus one flips the start parity
      start_odd = req.shift_flag ^ req.coord_y[0] ^ req.coord_z[0] ^ req.coord_t[0];
      ix        = eff_cb ^ start_odd;
      last_full = half - HALF_W'(1) - HALF_W'(ix & odd_x);

      work.coord_y   = req.coord_y;
      work.coord_z   = req.coord_z;
      work.coord_t   = req.coord_t;
      work.disp      = req.boundary_pad ^ req.shift_flag;
      work.x_pad_off = ceil_mode ? (ix | req.shift_flag)
                                 : (req.shift_flag ? ix : req.boundary_pad);
      work.x_off     = ceil_mode & ix;
      work.last_x    = last_full[LAST_W-1:0];
      work.err       = ({1'b0, req.coord_y} >= cfg.extent_y) ||
                       ({1'b0, req.coord_z} >= cfg.extent_z) ||
                       ({1'b0, req.coord_t} >= cfg.extent_t);
   end

endmodule

[sv/csag_queue.sv]
// small fifo between the front end and the address pipeline
module csag_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  csag_pkg::work_type push_work,
   output logic               pop_valid,
   input  logic               pop_ready,
   output csag_pkg::work_type pop_work
);
   import csag_pkg::*;

   work_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    push;
   logic                    pop;

   always_comb begin
      push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_work   = entry_ff[rd_ptr_ff];
      push       = push_valid & push_ready;
      pop        = pop_valid & pop_ready;
      wr_ptr_in  = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

[sv/csag_back.sv]
// back end: four stage address pipeline, one multiply level per stage
module csag_back (
   input  logic               clock,
   input  logic               reset,
   input  csag_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  csag_pkg::work_type in_work,
   output logic               out_valid,
   input  logic               out_ready,
   output csag_pkg::rsp_type  out_rsp
);
   import csag_pkg::*;

   typedef struct packed {
      logic [MUL1_W-1:0]  m_zt;    // ez * t
      logic [MUL1_W-1:0]  m_zt1;   // (ez + 1) * t
      logic [MUL1_W-1:0]  m_ztd;   // ez * (t + disp)
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic               disp;
      logic               x_pad_off;
      logic               x_off;
      logic [LAST_W-1:0]  last_x;
      logic               err;
   } st1_type;

   typedef struct packed {
      logic [MUL2_W-1:0]  u0;
      logic [MUL2_W-1:0]  u1;
      logic [MUL2_W-1:0]  u2;
      logic [MUL2_W-1:0]  u3;
      logic [COORD_W-1:0] coord_y;
      logic               disp;
      logic               x_pad_off;
      logic               x_off;
      logic [LAST_W-1:0]  last_x;
      logic               err;
   } st2_type;

   typedef struct packed {
      logic [MUL3_W-1:0] v0;
      logic [MUL3_W-1:0] v1;
      logic [MUL3_W-1:0] v2;
      logic [MUL3_W-1:0] v3;
      logic              x_pad_off;
      logic              x_off;
      logic [LAST_W-1:0] last_x;
      logic              err;
   } st3_type;

   st1_type           st1_ff, st1_in;
   st2_type           st2_ff, st2_in;
   st3_type           st3_ff, st3_in;
   rsp_type           out_ff, out_in;
   logic              st1_valid_ff, st1_valid_in;
   logic              st2_valid_ff, st2_valid_in;
   logic              st3_valid_ff, st3_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              st1_adv, st2_adv, st3_adv, out_adv;
   logic [HALF_W-1:0] half;
   logic [MUL1_W-1:0] zt_sum;
   logic [MUL1_W-1:0] ztd_sum;
   logic [MUL1_W-1:0] zt1_sum;

   // a stage moves when it is empty or its successor moves
   always_comb begin
      out_adv  = ~out_valid_ff | out_ready;
      st3_adv  = ~st3_valid_ff | out_adv;
      st2_adv  = ~st2_valid_ff | st3_adv;
      st1_adv  = ~st1_valid_ff | st2_adv;
      in_ready = st1_adv;

      st1_valid_in = st1_adv ? in_valid     : st1_valid_ff;
      st2_valid_in = st2_adv ? st1_valid_ff : st2_valid_ff;
      st3_valid_in = st3_adv ? st2_valid_ff : st3_valid_ff;
      out_valid_in = out_adv ? st3_valid_ff : out_valid_ff;

      out_valid = out_valid_ff;
      out_rsp   = out_ff;
   end

   // stage 1: products along t
   always_comb begin
      st1_in.m_zt      = MUL1_W'(cfg.extent_z) * MUL1_W'(in_work.coord_t);
      st1_in.m_zt1     = (MUL1_W'(cfg.extent_z) + MUL1_W'(1)) * MUL1_W'(in_work.coord_t);
      st1_in.m_ztd     = MUL1_W'(cfg.extent_z) *
                         (MUL1_W'(in_work.coord_t) + MUL1_W'(in_work.disp));
      st1_in.coord_y   = in_work.coord_y;
      st1_in.coord_z   = in_work.coord_z;
      st1_in.disp      = in_work.disp;
      st1_in.x_pad_off = in_work.x_pad_off;
      st1_in.x_off     = in_work.x_off;
      st1_in.last_x    = in_work.last_x;
      st1_in.err       = in_work.err;
   end

   // stage 2: products along z
   always_comb begin
      zt_sum  = MUL1_W'(st1_ff.coord_z) + st1_ff.m_zt;
      zt1_sum = MUL1_W'(st1_ff.coord_z) + MUL1_W'(st1_ff.disp) + st1_ff.m_zt1;
      ztd_sum = MUL1_W'(st1_ff.coord_z) + st1_ff.m_ztd;

      st2_in.u0        = MUL2_W'(cfg.extent_y) * MUL2_W'(zt_sum);
      st2_in.u1        = (MUL2_W'(cfg.extent_y) + MUL2_W'(1)) * MUL2_W'(zt_sum);
      st2_in.u2        = MUL2_W'(cfg.extent_y) * MUL2_W'(zt1_sum);
      st2_in.u3        = MUL2_W'(cfg.extent_y) * MUL2_W'(ztd_sum);
      st2_in.coord_y   = st1_ff.coord_y;
      st2_in.disp      = st1_ff.disp;
      st2_in.x_pad_off = st1_ff.x_pad_off;
      st2_in.x_off     = st1_ff.x_off;
      st2_in.last_x    = st1_ff.last_x;
      st2_in.err       = st1_ff.err;
   end

   // stage 3: products along y, scaled by the half extent
   always_comb begin
      half = half_extent(cfg.extent_x);

      st3_in.v0 = (MUL3_W'(half) + MUL3_W'(1)) *
                  MUL3_W'(MUL2_W'(st2_ff.coord_y) + st2_ff.u0);
      st3_in.v1 = MUL3_W'(half) *
                  MUL3_W'(MUL2_W'(st2_ff.coord_y) + MUL2_W'(st2_ff.disp) + st2_ff.u1);
      st3_in.v2 = MUL3_W'(half) * MUL3_W'(MUL2_W'(st2_ff.coord_y) + st2_ff.u2);
      st3_in.v3 = MUL3_W'(half) * MUL3_W'(MUL2_W'(st2_ff.coord_y) + st2_ff.u3);
      st3_in.x_pad_off = st2_ff.x_pad_off;
      st3_in.x_off     = st2_ff.x_off;
      st3_in.last_x    = st2_ff.last_x;
      st3_in.err       = st2_ff.err;
   end

   // stage 4: x offset and block scaling, wraps to the address width
   always_comb begin
      out_in.addr_x_dir   = (ADDR_W'(st3_ff.v0) + ADDR_W'(st3_ff.x_pad_off)) *
                            ADDR_W'(BLOCK_WORDS);
      out_in.addr_y_dir   = (ADDR_W'(st3_ff.v1) + ADDR_W'(st3_ff.x_off)) *
                            ADDR_W'(BLOCK_WORDS);
      out_in.addr_z_dir   = (ADDR_W'(st3_ff.v2) + ADDR_W'(st3_ff.x_off)) *
                            ADDR_W'(BLOCK_WORDS);
      out_in.addr_t_dir   = (ADDR_W'(st3_ff.v3) + ADDR_W'(st3_ff.x_off)) *
                            ADDR_W'(BLOCK_WORDS);
      out_in.last_x_index = st3_ff.last_x;
      out_in.coord_error  = st3_ff.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
         st2_valid_ff <= st2_valid_in;
         st3_valid_ff <= st3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st1_adv) begin
         st1_ff <= st1_in;
      end
      if (st2_adv) begin
         st2_ff <= st2_in;
      end
      if (st3_adv) begin
         st3_ff <= st3_in;
      end
      if (out_adv) begin
         out_ff <= out_in;
      end
   end

endmodule

[sv/checkerboard_sublattice_address_gen.sv]
// top level of the checkerboard sublattice address generator
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_payload (csag_pkg::req_type)
//  rsp      out        rsp_valid / rsp_ready  rsp_payload (csag_pkg::rsp_type)
//  csr      in         csr_write_en           csr_index, csr_wdata
//
//  one request per cycle sustained while rsp_ready stays high, one result per request,
//  results in order; a request transfer writes the queue, then the request passes the
//  3 multiply stages and the output register before rsp_valid rises
//  the queue holds 4 classified requests, so the front keeps taking requests
//  while the pipeline is stalled by rsp_ready, until the queue is full
//  reset (synchronous, active high) empties queue and pipeline and loads
//  extents of 8 and an even sublattice origin
module checkerboard_sublattice_address_gen (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  csag_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output csag_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [csag_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [csag_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import csag_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [EXT_W-1:0] ext_clamped;
   work_type         front_work;
   work_type         queue_work;
   logic             queue_valid;
   logic             back_ready;

   // extents are held to 1..MAX_EXTENT on write
   always_comb begin
      if (csr_wdata == '0) begin
         ext_clamped = EXTENT_MIN;
      end else if (csr_wdata > EXTENT_MAX) begin
         ext_clamped = EXTENT_MAX;
      end else begin
         ext_clamped = csr_wdata;
      end

      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_EXTENT_X:   cfg_in.extent_x = ext_clamped;
            CSR_EXTENT_Y:   cfg_in.extent_y = ext_clamped;
            CSR_EXTENT_Z:   cfg_in.extent_z = ext_clamped;
            CSR_EXTENT_T:   cfg_in.extent_t = ext_clamped;
            CSR_SUB_PARITY: cfg_in.sublattice_parity = csr_wdata[0];
            default:        cfg_in = cfg_ff; // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extent_x          <= EXTENT_RESET;
         cfg_ff.extent_y          <= EXTENT_RESET;
         cfg_ff.extent_z          <= EXTENT_RESET;
         cfg_ff.extent_t          <= EXTENT_RESET;
         cfg_ff.sublattice_parity <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify the request as it arrives
   csag_front u_front (
      .cfg  (cfg_ff),
      .req  (req_payload),
      .work (front_work)
   );

   // decouples request intake from result stalls
   csag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_work  (front_work),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_work   (queue_work)
   );

   // address arithmetic and the result register
   csag_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (queue_valid),
      .in_ready  (back_ready),
      .in_work   (queue_work),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_payload)
   );

endmodule

[sv/csag_checker.sv]
// port level checks of the address generator and their binding
`include "checkerboard_sublattice_address_gen_macros.svh"

module csag_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input csag_pkg::rsp_type rsp_payload
);

   // a stalled result stays offered
   `CSAG_ASSERT(rsp_valid_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // a stalled result keeps its value
   `CSAG_ASSERT(rsp_data_hold, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "result changed while stalled")

   // reset leaves no result behind
   `CSAG_ASSERT_RST(rsp_empty_after_reset, reset |=> !rsp_valid, "result valid after reset")

   // reset leaves the queue empty and open
   `CSAG_ASSERT_RST(req_open_after_reset, reset |=> req_ready, "request side closed after reset")

endmodule

bind checkerboard_sublattice_address_gen csag_checker u_csag_checker (.*);

[sim/tb_top.sv]
// testbench for the checkerboard sublattice address generator: directed and random line requests
`timescale 1ns / 1ps

module tb_top;
   import csag_pkg::*;

   // margin that wait_idle waits after the last expected result
   localparam int PIPE_LATENCY = 4;
   // register indexes past the end of the register list, writes must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HIGH = 3'd7;
   localparam int RANDOM_PHASES   = 6;
   localparam int LINES_PER_PHASE = 80;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // local copy of the lattice configuration, already clamped
   int cfg_extent_x;
   int cfg_extent_y;
   int cfg_extent_z;
   int cfg_extent_t;
   int cfg_parity;

   // address sets predicted for accepted lines, oldest first
   rsp_type pending_addr_sets[$];
   int      mismatch_count = 0;
   // when set, neither side inserts idle cycles
   bit      no_idle = 1'b0;

   checkerboard_sublattice_address_gen uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // written extent of 0 reads as 1, anything above the maximum reads as the maximum
   function automatic int clamp_extent(input logic [CSR_DATA_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_EXTENT) return MAX_EXTENT;
      return int'(value);
   endfunction

   // floor and ceiling of v/2, v is never below -1
   function automatic int floor_half(input int v);
      return v >>> 1;
   endfunction

   function automatic int ceil_half(input int v);
      return (v < 0) ? 0 : (v + 1) / 2;
   endfunction

   // start addresses of one x-line in the four padded buffers
   function automatic rsp_type predict_line_addresses(input req_type line);
      int      half, odd_x, pad, shift, eff_cb, start_odd;
      int      ix, last, xs, xo, disp, y, z, t, ey, ez;
      int      a_x, a_y, a_z, a_t;
      rsp_type p;
      ey        = cfg_extent_y;
      ez        = cfg_extent_z;
      y         = int'(line.coord_y);
      z         = int'(line.coord_z);
      t         = int'(line.coord_t);
      odd_x     = cfg_extent_x % 2;
      half      = (cfg_extent_x + 1) / 2;
      pad       = int'(line.boundary_pad);
      // shift +1 without padding, -1 with padding, 0 when not shifting
      shift     = line.shift_flag ? (line.boundary_pad ? -1 : 1) : 0;
      // odd sublattice origin swaps the checkerboard meaning
      eff_cb    = cfg_parity ^ int'(line.checkerboard);
      start_odd = (shift + y + z + t) & 1;
      if (eff_cb == start_odd) begin
         ix   = 0;
         last = half - 1;
      end else begin
         ix   = 1;
         last = half - 1 - odd_x;
      end
      // odd extent_x without padding rounds the half index up
      if (odd_x == 1 && pad == 0) begin
         xs = ceil_half(ix + shift);
         xo = ceil_half(ix);
      end else begin
         xs = floor_half(ix + shift);
         xo = floor_half(ix);
      end
      disp = pad + shift;
      a_x  = pad + xs + (half + 1) * (y + ey * (z + ez * t));
      a_y  = xo + half * ((y + disp) + (ey + 1) * (z + ez * t));
      a_z  = xo + half * (y + ey * ((z + disp) + (ez + 1) * t));
      a_t  = xo + half * (y + ey * (z + ez * (t + disp)));
      p.addr_x_dir   = ADDR_W'(a_x * BLOCK_WORDS);
      p.addr_y_dir   = ADDR_W'(a_y * BLOCK_WORDS);
      p.addr_z_dir   = ADDR_W'(a_z * BLOCK_WORDS);
      p.addr_t_dir   = ADDR_W'(a_t * BLOCK_WORDS);
      // an empty line gives -1, which wraps to all ones
      p.last_x_index = LAST_W'(last);
      p.coord_error  = (y >= cfg_extent_y) || (z >= cfg_extent_z) || (t >= cfg_extent_t);
      return p;
   endfunction

   // one register write, then the enable drops
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_EXTENT_X:   cfg_extent_x = clamp_extent(value);
         CSR_EXTENT_Y:   cfg_extent_y = clamp_extent(value);
         CSR_EXTENT_Z:   cfg_extent_z = clamp_extent(value);
         CSR_EXTENT_T:   cfg_extent_t = clamp_extent(value);
         CSR_SUB_PARITY: cfg_parity   = int'(value[0]);
         default: ;
      endcase
   endtask

   // present one line request and hold it until the transfer
   // valid is only lowered here or in wait_idle, so it never gets two updates in one step
   task automatic send_line(input req_type line);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_addr_sets.push_back(predict_line_addresses(line));
   endtask

   function automatic req_type make_line(input bit cb, input bit pad, input bit shift,
                                         input int y, input int z, input int t);
      req_type line;
      line.checkerboard = cb;
      line.boundary_pad = pad;
      line.shift_flag   = shift;
      line.coord_y      = COORD_W'(y);
      line.coord_z      = COORD_W'(z);
      line.coord_t      = COORD_W'(t);
      return line;
   endfunction

   // mostly coordinates inside the lattice, some anywhere in the field
   function automatic req_type random_line();
      bit in_lattice;
      in_lattice = ($urandom_range(0, 4) != 0);
      if (in_lattice)
         return make_line(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)),
                          $urandom_range(0, cfg_extent_y - 1),
                          $urandom_range(0, cfg_extent_z - 1),
                          $urandom_range(0, cfg_extent_t - 1));
      return make_line(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)),
                       $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
   endfunction

   // stop sending and let every expected result come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_addr_sets.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   // extents biased toward the ends of the range and the clamped values
   function automatic logic [CSR_DATA_W-1:0] random_extent();
      case ($urandom_range(0, 9))
         0:       return CSR_DATA_W'(1);
         1:       return CSR_DATA_W'(MAX_EXTENT);
         2:       return CSR_DATA_W'(0);
         3:       return CSR_DATA_W'($urandom_range(MAX_EXTENT + 1, 63));
         4:       return CSR_DATA_W'(2);
         default: return CSR_DATA_W'($urandom_range(1, MAX_EXTENT));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // lines with the reset extents of 8 and even origin
   task automatic test_reset_defaults();
      send_line(make_line(0, 0, 0, 0, 0, 0));
      send_line(make_line(1, 0, 0, 7, 7, 7));
      // all coordinate bits set, beyond every extent
      send_line(make_line(1, 1, 1, 31, 31, 31));
      wait_idle();
   endtask

   // every checkerboard, padding and shift combination
   task automatic test_shift_rule();
      for (int c = 0; c < 8; c++)
         send_line(make_line(c[2], c[1], c[0], 1, 2, 3));
      wait_idle();
   endtask

   // odd sublattice origin, empty line at extent_x of 1, rounding for odd extent_x
   task automatic test_odd_origin_and_extent();
      write_csr(CSR_SUB_PARITY, CSR_DATA_W'(1));
      write_csr(CSR_EXTENT_X, CSR_DATA_W'(1));
      send_line(make_line(0, 0, 0, 0, 0, 0));
      send_line(make_line(1, 0, 0, 0, 0, 0));
      send_line(make_line(0, 1, 1, 0, 0, 0));
      wait_idle();
      write_csr(CSR_EXTENT_X, CSR_DATA_W'(7));
      send_line(make_line(0, 0, 1, 2, 1, 0));
      send_line(make_line(1, 0, 1, 2, 1, 0));
      send_line(make_line(1, 1, 1, 3, 4, 5));
      wait_idle();
   endtask

   // extents of 0 and above the maximum are clamped, unused indexes are dropped
   task automatic test_extent_clamp();
      write_csr(CSR_EXTENT_X, CSR_DATA_W'(0));
      write_csr(CSR_EXTENT_Y, CSR_DATA_W'(63));
      write_csr(CSR_EXTENT_Z, CSR_DATA_W'(MAX_EXTENT + 1));
      write_csr(CSR_EXTENT_T, CSR_DATA_W'(MAX_EXTENT));
      write_csr(CSR_SUB_PARITY, CSR_DATA_W'(0));
      write_csr(CSR_UNUSED_LOW, CSR_DATA_W'(63));
      write_csr(CSR_UNUSED_HIGH, CSR_DATA_W'(0));
      send_line(make_line(0, 1, 0, 31, 31, 31));
      send_line(make_line(1, 0, 1, 0, 0, 0));
      wait_idle();
      // largest lattice, highest coordinates give the top addresses
      write_csr(CSR_EXTENT_X, CSR_DATA_W'(MAX_EXTENT));
      send_line(make_line(0, 0, 1, 31, 31, 31));
      send_line(make_line(1, 1, 0, 31, 31, 31));
      wait_idle();
   endtask

   // random configurations, each followed by a run of random lines
   task automatic test_random_sweep();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_csr(CSR_EXTENT_X, random_extent());
         write_csr(CSR_EXTENT_Y, random_extent());
         write_csr(CSR_EXTENT_Z, random_extent());
         write_csr(CSR_EXTENT_T, random_extent());
         write_csr(CSR_SUB_PARITY, CSR_DATA_W'($urandom_range(0, 1)));
         if (phase == 3) write_csr(CSR_UNUSED_LOW, CSR_DATA_W'($urandom_range(0, 63)));
         // one phase runs flat out on both sides
         no_idle = (phase == 2);
         for (int n = 0; n < LINES_PER_PHASE; n++) begin
            send_line(random_line());
            // hold off mid-phase until the pipe is empty
            if (phase == 0 && n == LINES_PER_PHASE / 2) wait_idle();
         end
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side

   // result ready may drop at random before each transfer, unless no_idle is set
   initial begin : drive_rsp_ready
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && !reset)) @(posedge clock);
      end
   end

   // compare each result transfer against the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_addr_sets.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_addr_sets.pop_front();
            if (rsp_payload.addr_x_dir !== want.addr_x_dir) begin
               $error("addr_x_dir expected %0d got %0d", want.addr_x_dir, rsp_payload.addr_x_dir);
               mismatch_count++;
            end
            if (rsp_payload.addr_y_dir !== want.addr_y_dir) begin
               $error("addr_y_dir expected %0d got %0d", want.addr_y_dir, rsp_payload.addr_y_dir);
               mismatch_count++;
            end
            if (rsp_payload.addr_z_dir !== want.addr_z_dir) begin
               $error("addr_z_dir expected %0d got %0d", want.addr_z_dir, rsp_payload.addr_z_dir);
               mismatch_count++;
            end
            if (rsp_payload.addr_t_dir !== want.addr_t_dir) begin
               $error("addr_t_dir expected %0d got %0d", want.addr_t_dir, rsp_payload.addr_t_dir);
               mismatch_count++;
            end
            if (rsp_payload.last_x_index !== want.last_x_index) begin
               $error("last_x_index expected %0d got %0d", want.last_x_index,
                      rsp_payload.last_x_index);
               mismatch_count++;
            end
            if (rsp_payload.coord_error !== want.coord_error) begin
               $error("coord_error expected %0d got %0d", want.coord_error,
                      rsp_payload.coord_error);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : run_tests
      // known values on every input from time zero
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      cfg_extent_x = int'(EXTENT_RESET);
      cfg_extent_y = int'(EXTENT_RESET);
      cfg_extent_z = int'(EXTENT_RESET);
      cfg_extent_t = int'(EXTENT_RESET);
      cfg_parity   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_shift_rule();
      test_odd_origin_and_extent();
      test_extent_clamp();
      test_random_sweep();

      // wait_idle at the end of each test already drained the pipe
      if (mismatch_count == 0 && pending_addr_sets.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : run_limit
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/csag_pkg.sv
sv/csag_front.sv
sv/csag_queue.sv
sv/csag_back.sv
sv/checkerboard_sublattice_address_gen.sv
sv/csag_checker.sv
sim/tb_top.sv
